// ===== hw/rtl/kdmc_pkg.sv =====
package kdmc_pkg;

    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_PRESS   = 4'd1;
    localparam logic [3:0] EV_RELEASE = 4'd2;
    localparam logic [3:0] EV_X1      = 4'd3;
    localparam logic [3:0] EV_LONG    = 4'd8;

    localparam logic [2:0] CLICK_LIMIT = 3'd5;

    localparam logic [2:0] REG_DEBOUNCE_TICKS      = 3'd0;
    localparam logic [2:0] REG_RELEASE_TIMER_START = 3'd1;
    localparam logic [2:0] REG_MULTI_CLICK_WINDOW  = 3'd2;
    localparam logic [2:0] REG_HOLD_TIMER_MAX      = 3'd3;
    localparam logic [2:0] REG_HOLD_TIMER_START    = 3'd4;
    localparam logic [2:0] REG_RELEASE_TIMER_MAX   = 3'd5;
    localparam logic [2:0] REG_LONG_PRESS_TICKS    = 3'd6;

    localparam logic [7:0] RST_DEBOUNCE_TICKS      = 8'd3;
    localparam logic [7:0] RST_RELEASE_TIMER_START = 8'd0;
    localparam logic [7:0] RST_MULTI_CLICK_WINDOW  = 8'd30;
    localparam logic [7:0] RST_HOLD_TIMER_MAX      = 8'd250;
    localparam logic [7:0] RST_HOLD_TIMER_START    = 8'd0;
    localparam logic [7:0] RST_RELEASE_TIMER_MAX   = 8'd250;
    localparam logic [7:0] RST_LONG_PRESS_TICKS    = 8'd200;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] release_timer_start;
        logic [7:0] multi_click_window;
        logic [7:0] hold_timer_max;
        logic [7:0] hold_timer_start;
        logic [7:0] release_timer_max;
        logic [7:0] long_press_ticks;
    } kdmc_cfg_t;

    typedef struct packed {
        logic [7:0] debounce_count;
        logic [7:0] release_timer;
        logic [7:0] hold_timer;
        logic [2:0] click_count;
        logic [7:0] window_countdown;
        logic       released_flag;
    } kdmc_state_t;

endpackage

// ===== hw/rtl/kdmc_step.sv =====
module kdmc_step (
    input  kdmc_pkg::kdmc_cfg_t   cfg,
    input  kdmc_pkg::kdmc_state_t cur,
    input  logic                  level,
    output kdmc_pkg::kdmc_state_t nxt,
    output logic [3:0]            event_res
);
    import kdmc_pkg::*;

    kdmc_state_t s;
    logic [3:0]  ev;

    always_comb
    begin
        s  = cur;
        ev = EV_NONE;

        if (level)
        begin
            priority if (cur.debounce_count < cfg.debounce_ticks)
            begin
                s.debounce_count = cur.debounce_count + 8'd1;
                s.release_timer  = cfg.release_timer_start;
            end
            else if (cur.debounce_count == cfg.debounce_ticks)
            begin
                ev                 = EV_PRESS;
                s.debounce_count   = cur.debounce_count + 8'd1;
                s.click_count      = cur.click_count + 3'd1;
                s.window_countdown = cfg.multi_click_window;
                s.released_flag    = 1'b0;
            end
            else if (cur.hold_timer < cfg.hold_timer_max)
            begin
                s.hold_timer = cur.hold_timer + 8'd1;
            end
        end
        else if (cur.debounce_count != 8'd0)
        begin
            s.debounce_count = {1'b0, cur.debounce_count[7:1]};
            if (cur.release_timer == 8'd0)
            begin
                s.release_timer = 8'd1;
                ev              = EV_RELEASE;
                s.hold_timer    = 8'd0;
            end
        end
        else
        begin
            s.hold_timer    = cfg.hold_timer_start;
            s.released_flag = 1'b1;
            if (cur.release_timer < cfg.release_timer_max)
                s.release_timer = cur.release_timer + 8'd1;
            if (cur.click_count == 3'd0)
                s.release_timer = 8'd1;
        end

        if (s.window_countdown != 8'd0)
            s.window_countdown = s.window_countdown - 8'd1;

        // report clicks once the window closes after release, or at the limit
        if ((s.window_countdown == 8'd0 && s.released_flag) || s.click_count >= CLICK_LIMIT)
        begin
            if (s.click_count != 3'd0 && s.click_count <= CLICK_LIMIT)
                ev = EV_X1 + {1'b0, s.click_count} - 4'd1;
            s.click_count = 3'd0;
        end

        if (s.hold_timer == cfg.long_press_ticks)
        begin
            ev            = EV_LONG;
            s.click_count = 3'd0;
        end

        nxt       = s;
        event_res = ev;
    end

endmodule

// ===== hw/rtl/key_debounce_multi_click.sv =====
// Button debounce with press, release, multi-click and long-press events.
// Input stream (s_*): one request per sampled tick, s_tdata[0] = level
// (1 pressed). Output stream (m_*): exactly one request per input request,
// m_tdata[3:0] = event code (0 none, 1 press, 2 release, 3..7 one to five
// clicks, 8 long press).
// Latency: the result is valid on m_tvalid the cycle after the input is
// taken. Throughput: one item per cycle; the whole state update is one
// pass of small counters and compares between state and output register.
// When the receiver stalls, the one-entry output register holds its
// result and s_tready drops until that result is taken.
// Configuration: cfg_valid/cfg_ready write 8-bit cfg_data into the
// register at cfg_index (0..6); cfg_ready is always high, index 7 is
// ignored. Write only while no item is in flight.
// Reset clears all counters and flags, loads default register values and
// empties the output register.
module key_debounce_multi_click (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] level, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] event_res, [7:4] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import kdmc_pkg::*;

    kdmc_cfg_t   cfg_reg;
    kdmc_state_t state_reg;
    kdmc_state_t state_next;
    logic        out_valid_reg;
    logic [3:0]  out_event_reg;
    logic [3:0]  event_next;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_event_reg};

    kdmc_step u_step (
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .level     (s_tdata[0]),
        .nxt       (state_next),
        .event_res (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= RST_DEBOUNCE_TICKS;
            cfg_reg.release_timer_start <= RST_RELEASE_TIMER_START;
            cfg_reg.multi_click_window  <= RST_MULTI_CLICK_WINDOW;
            cfg_reg.hold_timer_max      <= RST_HOLD_TIMER_MAX;
            cfg_reg.hold_timer_start    <= RST_HOLD_TIMER_START;
            cfg_reg.release_timer_max   <= RST_RELEASE_TIMER_MAX;
            cfg_reg.long_press_ticks    <= RST_LONG_PRESS_TICKS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:      cfg_reg.debounce_ticks      <= cfg_data;
                REG_RELEASE_TIMER_START: cfg_reg.release_timer_start <= cfg_data;
                REG_MULTI_CLICK_WINDOW:  cfg_reg.multi_click_window  <= cfg_data;
                REG_HOLD_TIMER_MAX:      cfg_reg.hold_timer_max      <= cfg_data;
                REG_HOLD_TIMER_START:    cfg_reg.hold_timer_start    <= cfg_data;
                REG_RELEASE_TIMER_MAX:   cfg_reg.release_timer_max   <= cfg_data;
                REG_LONG_PRESS_TICKS:    cfg_reg.long_press_ticks    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_event_reg <= event_next;
    end

endmodule

// ===== test/key_debounce_multi_click_tb.sv =====
module key_debounce_multi_click_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdmc_pkg::*;

    localparam int NUM_REGS    = int'(REG_LONG_PRESS_TICKS) + 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF    = 150;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;
    typedef enum {STRESS_NONE, STRESS_HOLD_OFF, STRESS_PAUSE} stress_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;   // [0] level, [7:1] zero
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;        // [3:0] event code, [7:4] zero
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // predictor state and register shadow
    logic [7:0] press_cnt = '0;
    logic [7:0] rel_tmr = '0;
    logic [7:0] hold_tmr = '0;
    logic [2:0] click_cnt = '0;
    logic [7:0] window_left = '0;
    logic       release_seen = 1'b0;
    logic [7:0] cfg_regs [NUM_REGS];

    logic       level_queue [$];
    logic [3:0] expected_events [$];
    logic [3:0] event_want;

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  src_hold = 1'b0;
    int  hold_off_tag = 0;
    int  hold_off_seen = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  mismatches = 0;
    int  ticks_done = 0;
    int  settings_count = 0;
    int  ev_count [16];

    key_debounce_multi_click u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Event for one sampled tick; later rules in the tick override earlier ones.
    function automatic logic [3:0] next_event(input logic level);
        logic [3:0] ev;
        ev = EV_NONE;
        if (level)
        begin
            if (press_cnt < cfg_regs[REG_DEBOUNCE_TICKS])
            begin
                press_cnt = press_cnt + 8'd1;
                rel_tmr   = cfg_regs[REG_RELEASE_TIMER_START];
            end
            else if (press_cnt == cfg_regs[REG_DEBOUNCE_TICKS])
            begin
                ev           = EV_PRESS;
                press_cnt    = press_cnt + 8'd1;   // wraps at 255
                click_cnt    = click_cnt + 3'd1;
                window_left  = cfg_regs[REG_MULTI_CLICK_WINDOW];
                release_seen = 1'b0;
            end
            else if (hold_tmr < cfg_regs[REG_HOLD_TIMER_MAX])
            begin
                hold_tmr = hold_tmr + 8'd1;
            end
        end
        else
        begin
            if (press_cnt != 8'd0)
            begin
                press_cnt = press_cnt >> 1;
                if (rel_tmr == 8'd0)
                begin
                    rel_tmr  = 8'd1;
                    ev       = EV_RELEASE;
                    hold_tmr = 8'd0;
                end
            end
            else
            begin
                hold_tmr     = cfg_regs[REG_HOLD_TIMER_START];
                release_seen = 1'b1;
                if (rel_tmr < cfg_regs[REG_RELEASE_TIMER_MAX])
                    rel_tmr = rel_tmr + 8'd1;
                if (click_cnt == 3'd0)
                    rel_tmr = 8'd1;
            end
        end

        if (window_left != 8'd0)
            window_left = window_left - 8'd1;

        if ((window_left == 8'd0 && release_seen) || click_cnt >= CLICK_LIMIT)
        begin
            if (click_cnt >= 3'd1 && click_cnt <= CLICK_LIMIT)
                ev = EV_X1 + 4'(click_cnt) - 4'd1;
            click_cnt = 3'd0;
        end

        if (hold_tmr == cfg_regs[REG_LONG_PRESS_TICKS])
        begin
            ev        = EV_LONG;
            click_cnt = 3'd0;
        end
        return ev;
    endfunction

    // level driver: head of the queue stays offered until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_events.push_back(next_event(s_tdata[0]));
                void'(level_queue.pop_front());
                ticks_done++;
            end
            if (s_tvalid && !s_tready)
            begin
                // request still pending
            end
            else if (level_queue.size() != 0 && !src_hold
                     && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, level_queue[0]};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // event monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: event %0d arrived with none expected", $time, m_tdata[3:0]);
                    mismatches++;
                end
                else
                begin
                    event_want = expected_events.pop_front();
                    if (m_tdata[3:0] !== event_want)
                    begin
                        $display("%0t: event mismatch, expected %0d, got %0d",
                                 $time, event_want, m_tdata[3:0]);
                        mismatches++;
                    end
                    ev_count[m_tdata[3:0]]++;
                end
            end
            if (hold_off_tag != hold_off_seen)
            begin
                hold_off_seen = hold_off_tag;
                stall_left    = HOLD_OFF;
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[key_debounce_multi_click] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic configure(input logic [7:0] dbt, input logic [7:0] rts,
                             input logic [7:0] win, input logic [7:0] hmax,
                             input logic [7:0] hst, input logic [7:0] rmax,
                             input logic [7:0] lpt);
        logic [7:0] vals [NUM_REGS];
        vals[REG_DEBOUNCE_TICKS]      = dbt;
        vals[REG_RELEASE_TIMER_START] = rts;
        vals[REG_MULTI_CLICK_WINDOW]  = win;
        vals[REG_HOLD_TIMER_MAX]      = hmax;
        vals[REG_HOLD_TIMER_START]    = hst;
        vals[REG_RELEASE_TIMER_MAX]   = rmax;
        vals[REG_LONG_PRESS_TICKS]    = lpt;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            cfg_regs[i] = vals[i];
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic queue_run(input logic level, input int len);
        for (int i = 0; i < len; i++)
            level_queue.push_back(level);
    endtask

    // Mostly press/release bursts sized around the current thresholds,
    // with some random chatter mixed in.
    task automatic queue_phase(input int budget);
        int db, win, lpt, n, k, pick, plen, gap;
        db  = cfg_regs[REG_DEBOUNCE_TICKS];
        win = cfg_regs[REG_MULTI_CLICK_WINDOW];
        lpt = cfg_regs[REG_LONG_PRESS_TICKS];
        n = 0;
        while (n < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                k = $urandom_range(1, 10);
                for (int i = 0; i < k; i++)
                    level_queue.push_back(1'($urandom_range(1)));
                n += k;
            end
            else
            begin
                k = $urandom_range(1, 6);
                for (int j = 0; j < k && n < budget; j++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        plen = $urandom_range(1, db + 1);
                    else if (pick < 88)
                        plen = db + 1 + $urandom_range(0, 3);
                    else
                        plen = db + lpt + $urandom_range(0, 4);
                    gap = $urandom_range(1, 10);
                    queue_run(1'b1, plen);
                    queue_run(1'b0, gap);
                    n += plen + gap;
                end
                // closing release, sometimes cut before the window runs out
                if ($urandom_range(3) == 0)
                    gap = $urandom_range(1, win + 1);
                else
                    gap = win + 10 + $urandom_range(0, 6);
                queue_run(1'b0, gap);
                n += gap;
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (level_queue.size() != 0 || s_tvalid || expected_events.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_phase(input idle_mode_e mode, input int budget, input stress_e stress);
        case (mode)
            IDLE_NONE: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
            IDLE_SRC:  begin src_idle_pct <= 70; sink_stall_pct <= 0;  end
            IDLE_SINK: begin src_idle_pct <= 0;  sink_stall_pct <= 70; end
            default:   begin src_idle_pct <= 27; sink_stall_pct <= 27; end
        endcase
        queue_phase(budget);
        if (stress == STRESS_HOLD_OFF)
        begin
            repeat (20) @(posedge clk);
            hold_off_tag <= hold_off_tag + 1;
        end
        else if (stress == STRESS_PAUSE)
        begin
            do @(posedge clk); while (level_queue.size() > budget / 2);
            src_hold <= 1'b1;
            do @(posedge clk); while (s_tvalid || expected_events.size() != 0);
            src_hold <= 1'b0;
        end
        wait_idle();
    endtask

    initial
    begin
        cfg_regs[REG_DEBOUNCE_TICKS]      = RST_DEBOUNCE_TICKS;
        cfg_regs[REG_RELEASE_TIMER_START] = RST_RELEASE_TIMER_START;
        cfg_regs[REG_MULTI_CLICK_WINDOW]  = RST_MULTI_CLICK_WINDOW;
        cfg_regs[REG_HOLD_TIMER_MAX]      = RST_HOLD_TIMER_MAX;
        cfg_regs[REG_HOLD_TIMER_START]    = RST_HOLD_TIMER_START;
        cfg_regs[REG_RELEASE_TIMER_MAX]   = RST_RELEASE_TIMER_MAX;
        cfg_regs[REG_LONG_PRESS_TICKS]    = RST_LONG_PRESS_TICKS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: five quick clicks report at once, then a long press
        configure(8'd2, 8'd0, 8'd20, 8'd8, 8'd0, 8'd250, 8'd6);
        repeat (5)
        begin
            queue_run(1'b1, 3);
            queue_run(1'b0, 2);
        end
        queue_run(1'b1, 9);
        queue_run(1'b0, 3);
        wait_idle();

        configure(RST_DEBOUNCE_TICKS, RST_RELEASE_TIMER_START, RST_MULTI_CLICK_WINDOW,
                  RST_HOLD_TIMER_MAX, RST_HOLD_TIMER_START, RST_RELEASE_TIMER_MAX,
                  RST_LONG_PRESS_TICKS);
        run_phase(IDLE_SRC, 250, STRESS_NONE);

        configure(8'd1, 8'd0, 8'd1, 8'd255, 8'd0, 8'd255, 8'd1);
        run_phase(IDLE_SINK, 200, STRESS_HOLD_OFF);

        // hold start equal to the long-press value: long events while released
        configure(8'd254, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        run_phase(IDLE_BOTH, 100, STRESS_NONE);

        // debounce count wraps at 255; suppressed release events
        configure(8'd255, 8'd1, 8'd20, 8'd3, 8'd2, 8'd5, 8'd2);
        run_phase(IDLE_NONE, 100, STRESS_PAUSE);

        configure(8'd0, 8'd2, 8'd12, 8'd40, 8'd3, 8'd10, 8'd20);
        run_phase(IDLE_BOTH, 180, STRESS_HOLD_OFF);

        configure(8'($urandom_range(0, 12)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 60)));
        run_phase(IDLE_SRC, 150, STRESS_NONE);

        configure(8'($urandom_range(1, 8)), 8'($urandom_range(3)),
                  8'($urandom_range(1, 40)), 8'($urandom_range(255)),
                  8'($urandom_range(40)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 40)));
        run_phase(IDLE_NONE, 150, STRESS_NONE);

        $display("Ran %0d button ticks over %0d register settings with varied stalls",
                 ticks_done, settings_count);
        $display("Events seen: %0d press, %0d release, %0d click reports, %0d long press",
                 ev_count[EV_PRESS], ev_count[EV_RELEASE],
                 ev_count[3] + ev_count[4] + ev_count[5] + ev_count[6] + ev_count[7],
                 ev_count[EV_LONG]);
        if (mismatches == 0 && expected_events.size() == 0)
        begin
            $display("[key_debounce_multi_click] OK");
        end
        else
        begin
            $display("[key_debounce_multi_click] ERROR");
        end
        $finish;
    end

endmodule
